// File: design/door_controller_with_quadrature_count_macros.svh
// Assertion macros for the door controller.
// Each takes a label, clock, active-low reset, antecedent and consequent.
`ifndef DOOR_CONTROLLER_WITH_QUADRATURE_COUNT_MACROS_SVH
`define DOOR_CONTROLLER_WITH_QUADRATURE_COUNT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define DCQC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dcqc assertion failed");

// Next-cycle implication
`define DCQC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dcqc assertion failed");

`else

`define DCQC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DCQC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/dcqc_pkg.sv
package dcqc_pkg;

    // Default width of the position counter
    localparam int POSITION_BITS_DEFAULT = 16;

    // Door modes
    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_CLOSED  = 3'd1;
    localparam logic [2:0] MODE_OPENING = 3'd2;
    localparam logic [2:0] MODE_OPEN    = 3'd3;
    localparam logic [2:0] MODE_CLOSING = 3'd4;

    // Saved door state codes
    localparam logic [1:0] SAVED_CLOSED = 2'd1;
    localparam logic [1:0] SAVED_OPEN   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_UPPER_LIMIT = 2'd0;
    localparam logic [1:0] CFG_LOWER_LIMIT = 2'd1;
    localparam logic [1:0] CFG_RESTORED    = 2'd2;

    // Item kinds
    localparam logic ACTION_TICK    = 1'b0;
    localparam logic ACTION_ENCODER = 1'b1;

    typedef struct packed {
        logic action;
        logic chan_a;
        logic chan_b;
        logic button_pressed;
    } t_in_item;

    typedef struct packed {
        logic               relay_up;
        logic               relay_down;
        logic [2:0]         door_mode;
        logic signed [15:0] position_count;
        logic               encoder_fault;
        logic               reference_lost;
    } t_out_item;

    // Configuration seen by the mode controller
    typedef struct packed {
        logic signed [15:0] open_stop;
        logic signed [15:0] close_stop;
        logic [1:0]         restored;
    } t_door_cfg;

endpackage

// File: design/dcqc_quad.sv
`include "door_controller_with_quadrature_count_macros.svh"

module dcqc_quad
    import dcqc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_chan_a,
    input  logic                     i_chan_b,
    output logic [POSITION_BITS-1:0] o_pos,
    output logic                     o_fault
);

    // Phase index along the forward cycle 00,01,11,10
    localparam logic [1:0] PHASE_RESET = 2'd2;
    localparam logic [1:0] STEP_FWD    = 2'd1;
    localparam logic [1:0] STEP_REV    = 2'd3;

    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic [1:0]               r_last;
    logic [1:0]               n_last;
    logic [1:0]               new_phase;
    logic [1:0]               delta;

    assign new_phase = {i_chan_a, i_chan_a ^ i_chan_b};
    assign delta     = new_phase - r_last;

    // Step the counter; a repeated or skipped phase keeps the count and flags a fault
    always_comb begin
        n_pos   = r_pos;
        n_last  = r_last;
        o_fault = 1'b0;
        if (i_en) begin
            n_last = new_phase;
            unique case (delta)
                STEP_FWD: n_pos = r_pos + 1'b1;
                STEP_REV: n_pos = r_pos - 1'b1;
                default:  o_fault = 1'b1;
            endcase
        end
    end

    assign o_pos = n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_last <= PHASE_RESET;
        end else begin
            r_pos  <= n_pos;
            r_last <= n_last;
        end
    end

    `DCQC_ASSERT_NEXT(a_fault_holds_count, i_clk, i_rst_n, i_en && o_fault, r_pos == $past(r_pos))
    `DCQC_ASSERT_NEXT(a_step_moves_count, i_clk, i_rst_n, i_en && !o_fault, r_pos != $past(r_pos))
    `DCQC_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_en, $stable(r_pos) && $stable(r_last))

endmodule

// File: design/dcqc_fsm.sv
`include "door_controller_with_quadrature_count_macros.svh"

module dcqc_fsm
    import dcqc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick,
    input  logic                            i_btn,
    input  logic signed [POSITION_BITS-1:0] i_pos,
    input  t_door_cfg                       i_cfg,
    output logic [2:0]                      o_mode,
    output logic                            o_lost
);

    localparam int CMP_W = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    logic [2:0]               r_cur;
    logic [2:0]               n_cur;
    logic [2:0]               r_pend;
    logic [2:0]               n_pend;
    logic                     r_lost;
    logic                     n_lost;
    logic signed [CMP_W-1:0]  pos_ext;
    logic signed [CMP_W-1:0]  upper_ext;
    logic signed [CMP_W-1:0]  lower_ext;

    // Sign-extend both sides to a common width
    assign pos_ext   = CMP_W'(i_pos);
    assign upper_ext = CMP_W'(signed'(i_cfg.open_stop));
    assign lower_ext = CMP_W'(signed'(i_cfg.close_stop));

    // A tick makes the pending mode current, then takes one step
    always_comb begin
        n_cur  = i_tick ? r_pend : r_cur;
        n_pend = r_pend;
        n_lost = r_lost;
        if (i_tick) begin
            unique case (n_cur)
                MODE_INIT: begin
                    if (i_cfg.restored == SAVED_CLOSED) begin
                        n_pend = MODE_CLOSED;
                    end else if (i_cfg.restored == SAVED_OPEN) begin
                        n_pend = MODE_OPEN;
                    end else begin
                        n_lost = 1'b1;
                    end
                end
                MODE_CLOSED: begin
                    if (i_btn) n_pend = MODE_OPENING;
                end
                MODE_OPENING: begin
                    if (pos_ext >= upper_ext) n_pend = MODE_OPEN;
                end
                MODE_OPEN: begin
                    if (i_btn) n_pend = MODE_CLOSING;
                end
                MODE_CLOSING: begin
                    if (pos_ext <= lower_ext) n_pend = MODE_CLOSED;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_mode = n_cur;
    assign o_lost = n_lost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= MODE_INIT;
            r_pend <= MODE_INIT;
            r_lost <= 1'b0;
        end else begin
            r_cur  <= n_cur;
            r_pend <= n_pend;
            r_lost <= n_lost;
        end
    end

    `DCQC_ASSERT_NEXT(a_lost_sticky, i_clk, i_rst_n, r_lost, r_lost)
    `DCQC_ASSERT_NEXT(a_no_tick_holds, i_clk, i_rst_n, !i_tick, $stable(r_cur) && $stable(r_pend))
    `DCQC_ASSERT_NEXT(a_tick_takes_pending, i_clk, i_rst_n, i_tick, r_cur == $past(r_pend))

endmodule

// File: design/door_controller_with_quadrature_count.sv
// An accepted item sits in the input register; its result is written to the
// result register when that register is empty or being read, raising o_out_valid.
// Throughput: one item per cycle; a held-off result stalls the input.
// Reset (synchronous, active low) clears both registers' valid bits, the mode
// state, the lost flag, the position (zero), the phase (11) and the config.
`include "door_controller_with_quadrature_count_macros.svh"

module door_controller_with_quadrature_count
    import dcqc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic                     r_in_valid;
    t_in_item                 r_in;
    logic                     r_out_valid;
    t_out_item                r_out;
    t_door_cfg                r_cfg;
    logic                     advance;
    logic                     is_encoder;
    logic                     is_tick;
    logic [POSITION_BITS-1:0] pos_next;
    logic                     fault;
    logic [2:0]               mode_next;
    logic                     lost_next;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UPPER_LIMIT: r_cfg.open_stop  <= signed'(i_cfg_data);
                CFG_LOWER_LIMIT: r_cfg.close_stop <= signed'(i_cfg_data);
                CFG_RESTORED:    r_cfg.restored   <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign is_encoder = advance && (r_in.action == ACTION_ENCODER);
    assign is_tick    = advance && (r_in.action == ACTION_TICK);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    dcqc_quad #(
        .POSITION_BITS(POSITION_BITS)
    ) u_quad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (is_encoder),
        .i_chan_a (r_in.chan_a),
        .i_chan_b (r_in.chan_b),
        .o_pos    (pos_next),
        .o_fault  (fault)
    );

    dcqc_fsm #(
        .POSITION_BITS(POSITION_BITS)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (is_tick),
        .i_btn   (r_in.button_pressed),
        .i_pos   (signed'(pos_next)),
        .i_cfg   (r_cfg),
        .o_mode  (mode_next),
        .o_lost  (lost_next)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.relay_up       <= (mode_next == MODE_OPENING);
            r_out.relay_down     <= (mode_next == MODE_CLOSING);
            r_out.door_mode      <= mode_next;
            r_out.position_count <= signed'(16'(pos_next));
            r_out.encoder_fault  <= fault;
            r_out.reference_lost <= lost_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `DCQC_ASSERT_NOW(a_relays_exclusive, i_clk, i_rst_n, o_out_valid, !(r_out.relay_up && r_out.relay_down))
    `DCQC_ASSERT_NOW(a_tick_no_fault, i_clk, i_rst_n, is_tick, !fault)
    `DCQC_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid)

endmodule

// File: verif/tb_door_controller_with_quadrature_count.sv
module tb_door_controller_with_quadrature_count;
    import dcqc_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int SWEEP_STEPS     = 48;
    localparam int SETTLE_CYCLES   = 4;
    localparam int IDLE_PCT        = 28;

    // Phase index of A=1,B=1 along the forward cycle
    localparam logic [1:0] PHASE_HIGH_HIGH = 2'd2;
    localparam logic [1:0] FWD_STEP        = 2'd1;
    localparam logic [1:0] BACK_STEP       = 2'd3;
    // Index with no register behind it
    localparam logic [1:0] CFG_UNUSED      = 2'd3;

    typedef struct {
        logic        is_cfg;
        logic [1:0]  cfg_index;
        logic [15:0] cfg_data;
        t_in_item    item;
        logic        pinned;
        t_out_item   want;
    } t_row;

    typedef struct {
        logic      pinned;
        t_out_item want;
    } t_pin;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    // Predicted door state and its copy of the registers
    logic [2:0]         cur_mode    = MODE_INIT;
    logic [2:0]         next_mode   = MODE_INIT;
    logic [1:0]         enc_phase   = PHASE_HIGH_HIGH;
    logic signed [15:0] door_pos    = '0;
    logic               ref_lost    = 1'b0;
    logic signed [15:0] upper_lim   = '0;
    logic signed [15:0] lower_lim   = '0;
    logic [1:0]         saved_state = '0;

    t_out_item due_results[$];
    t_pin      pinned_results[$];
    t_row      dir_rows[$];

    int         n_fail      = 0;
    int         cycles      = 0;
    int         tx_idle_pct = IDLE_PCT;
    int         rx_idle_pct = IDLE_PCT;
    int         hold_req    = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;
    logic [1:0] tx_phase    = PHASE_HIGH_HIGH;

    door_controller_with_quadrature_count dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_in_item mk_in(input logic act, input logic a, input logic b,
                                       input logic btn);
        t_in_item it;
        it.action         = act;
        it.chan_a         = a;
        it.chan_b         = b;
        it.button_pressed = btn;
        return it;
    endfunction

    // Encoder item whose levels land on the given phase index
    function automatic t_in_item enc_item(input logic [1:0] phase_idx, input logic btn);
        return mk_in(ACTION_ENCODER, phase_idx[1], phase_idx[1] ^ phase_idx[0], btn);
    endfunction

    function automatic t_out_item mk_out(input logic up, input logic dn, input logic [2:0] mode,
                                         input logic [15:0] pos, input logic flt,
                                         input logic lost);
        t_out_item r;
        r.relay_up       = up;
        r.relay_down     = dn;
        r.door_mode      = mode;
        r.position_count = pos;
        r.encoder_fault  = flt;
        r.reference_lost = lost;
        return r;
    endfunction

    function automatic t_row row_cfg(input logic [1:0] idx, input logic [15:0] data);
        t_row r;
        r           = '{default: '0};
        r.is_cfg    = 1'b1;
        r.cfg_index = idx;
        r.cfg_data  = data;
        return r;
    endfunction

    function automatic t_row row_item(input t_in_item it, input logic pin, input t_out_item want);
        t_row r;
        r        = '{default: '0};
        r.item   = it;
        r.pinned = pin;
        r.want   = want;
        return r;
    endfunction

    // Advance the door model by one item and return its result
    function automatic t_out_item predict_door(input t_in_item it);
        t_out_item  r;
        logic [1:0] np;
        logic [1:0] step;
        logic       flt;
        flt = 1'b0;
        if (it.action == ACTION_ENCODER) begin
            np   = {it.chan_a, it.chan_a ^ it.chan_b};
            step = np - enc_phase;
            if (step == FWD_STEP) door_pos = door_pos + 16'sd1;
            else if (step == BACK_STEP) door_pos = door_pos - 16'sd1;
            else flt = 1'b1;
            enc_phase = np;
        end else begin
            cur_mode = next_mode;
            case (cur_mode)
                MODE_INIT: begin
                    if (saved_state == SAVED_CLOSED) next_mode = MODE_CLOSED;
                    else if (saved_state == SAVED_OPEN) next_mode = MODE_OPEN;
                    else ref_lost = 1'b1;
                end
                MODE_CLOSED:  if (it.button_pressed) next_mode = MODE_OPENING;
                MODE_OPENING: if (door_pos >= upper_lim) next_mode = MODE_OPEN;
                MODE_OPEN:    if (it.button_pressed) next_mode = MODE_CLOSING;
                MODE_CLOSING: if (door_pos <= lower_lim) next_mode = MODE_CLOSED;
                default: ;
            endcase
        end
        r.relay_up       = (cur_mode == MODE_OPENING);
        r.relay_down     = (cur_mode == MODE_CLOSING);
        r.door_mode      = cur_mode;
        r.position_count = door_pos;
        r.encoder_fault  = flt;
        r.reference_lost = ref_lost;
        return r;
    endfunction

    function automatic void check_result(input t_out_item want, input t_out_item got);
        if (got.relay_up !== want.relay_up) begin
            n_fail++;
            $display("%0t: relay_up expected %0d actual %0d", $time, want.relay_up,
                     got.relay_up);
        end
        if (got.relay_down !== want.relay_down) begin
            n_fail++;
            $display("%0t: relay_down expected %0d actual %0d", $time, want.relay_down,
                     got.relay_down);
        end
        if (got.door_mode !== want.door_mode) begin
            n_fail++;
            $display("%0t: door_mode expected %0d actual %0d", $time, want.door_mode,
                     got.door_mode);
        end
        if (got.position_count !== want.position_count) begin
            n_fail++;
            $display("%0t: position_count expected %0d actual %0d", $time,
                     want.position_count, got.position_count);
        end
        if (got.encoder_fault !== want.encoder_fault) begin
            n_fail++;
            $display("%0t: encoder_fault expected %0d actual %0d", $time, want.encoder_fault,
                     got.encoder_fault);
        end
        if (got.reference_lost !== want.reference_lost) begin
            n_fail++;
            $display("%0t: reference_lost expected %0d actual %0d", $time,
                     want.reference_lost, got.reference_lost);
        end
    endfunction

    // Hold the input side idle until every result is back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one item, with random idle cycles ahead of it
    task automatic send_item(input t_in_item it, input logic pin, input t_out_item want);
        t_pin p;
        p.pinned = pin;
        p.want   = want;
        pinned_results.push_back(p);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Track config writes and items, compare each result with the oldest due
    always @(posedge i_clk) begin : door_monitor
        t_out_item want;
        t_pin      p;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_UPPER_LIMIT: upper_lim   = i_cfg_data;
                    CFG_LOWER_LIMIT: lower_lim   = i_cfg_data;
                    CFG_RESTORED:    saved_state = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                want = predict_door(i_in_item);
                if (pinned_results.size() != 0) begin
                    p = pinned_results.pop_front();
                    if (p.pinned) want = p.want;
                end
                due_results.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    n_fail++;
                    $display("%0t: result expected none actual %h", $time, o_out_item);
                end else begin
                    check_result(due_results.pop_front(), o_out_item);
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int          j;
        int          n;
        int          ph;
        int          r;
        int          sweep_from;
        int          sweep_len;
        logic        fwd;
        logic [3:0]  noise;
        logic [15:0] lim_hi;
        logic [15:0] lim_lo;
        t_in_item    it;

        // Directed rows: reset state, phase errors, wrap below zero, every mode
        dir_rows.push_back(row_item(mk_in(ACTION_ENCODER, 1, 0, 0), 1,
                                    mk_out(0, 0, MODE_INIT, 16'h0001, 0, 0)));
        dir_rows.push_back(row_item(mk_in(ACTION_ENCODER, 1, 0, 1), 1,
                                    mk_out(0, 0, MODE_INIT, 16'h0001, 1, 0)));
        dir_rows.push_back(row_item(mk_in(ACTION_ENCODER, 0, 1, 0), 1,
                                    mk_out(0, 0, MODE_INIT, 16'h0001, 1, 0)));
        dir_rows.push_back(row_item(mk_in(ACTION_ENCODER, 0, 0, 0), 1,
                                    mk_out(0, 0, MODE_INIT, 16'h0000, 0, 0)));
        dir_rows.push_back(row_item(mk_in(ACTION_ENCODER, 1, 0, 0), 1,
                                    mk_out(0, 0, MODE_INIT, 16'hFFFF, 0, 0)));
        // unknown saved state flags the reference as lost
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 1, 1, 1), 1,
                                    mk_out(0, 0, MODE_INIT, 16'hFFFF, 0, 1)));
        dir_rows.push_back(row_cfg(CFG_RESTORED, 16'hFFFF));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 0), 1,
                                    mk_out(0, 0, MODE_INIT, 16'hFFFF, 0, 1)));
        dir_rows.push_back(row_cfg(CFG_UPPER_LIMIT, 16'h7FFF));
        dir_rows.push_back(row_cfg(CFG_LOWER_LIMIT, 16'h8000));
        dir_rows.push_back(row_cfg(CFG_RESTORED, 16'h0002));
        dir_rows.push_back(row_cfg(CFG_UNUSED, 16'h5A5A));
        // restore to open, then close down to the lower limit
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 0), 1,
                                    mk_out(0, 0, MODE_INIT, 16'hFFFF, 0, 1)));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 0), 1,
                                    mk_out(0, 0, MODE_OPEN, 16'hFFFF, 0, 1)));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 1), 1,
                                    mk_out(0, 0, MODE_OPEN, 16'hFFFF, 0, 1)));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 0), 1,
                                    mk_out(0, 1, MODE_CLOSING, 16'hFFFF, 0, 1)));
        dir_rows.push_back(row_item(mk_in(ACTION_ENCODER, 0, 0, 0), 1,
                                    mk_out(0, 1, MODE_CLOSING, 16'h0000, 0, 1)));
        dir_rows.push_back(row_cfg(CFG_LOWER_LIMIT, 16'h7FFF));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 0), 1,
                                    mk_out(0, 1, MODE_CLOSING, 16'h0000, 0, 1)));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 0), 1,
                                    mk_out(0, 0, MODE_CLOSED, 16'h0000, 0, 1)));
        // button opens, upper limit stops it
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 1), 1,
                                    mk_out(0, 0, MODE_CLOSED, 16'h0000, 0, 1)));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 0), 1,
                                    mk_out(1, 0, MODE_OPENING, 16'h0000, 0, 1)));
        dir_rows.push_back(row_cfg(CFG_UPPER_LIMIT, 16'h8000));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 1, 1, 0), 1,
                                    mk_out(1, 0, MODE_OPENING, 16'h0000, 0, 1)));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 1), 1,
                                    mk_out(0, 0, MODE_OPEN, 16'h0000, 0, 1)));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 0), 1,
                                    mk_out(0, 1, MODE_CLOSING, 16'h0000, 0, 1)));
        // mode change waits for the next tick
        dir_rows.push_back(row_item(mk_in(ACTION_ENCODER, 0, 1, 0), 1,
                                    mk_out(0, 1, MODE_CLOSING, 16'h0001, 0, 1)));
        dir_rows.push_back(row_item(mk_in(ACTION_TICK, 0, 0, 0), 0, '0));
        dir_rows.push_back(row_item(mk_in(ACTION_ENCODER, 1, 1, 1), 0, '0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) write_cfg(dir_rows[k].cfg_index, dir_rows[k].cfg_data);
            else send_item(dir_rows[k].item, dir_rows[k].pinned, dir_rows[k].want);
        end

        // Full-speed forward sweep while opening: reaches the top limit and runs past it
        write_cfg(CFG_LOWER_LIMIT, 16'h8000);
        sweep_from = int'(door_pos);
        write_cfg(CFG_UPPER_LIMIT, 16'(sweep_from + SWEEP_STEPS));
        tx_phase   = enc_phase;
        sweep_len  = SWEEP_STEPS;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(mk_in(ACTION_TICK, 0, 0, 1), 0, '0);
        send_item(mk_in(ACTION_TICK, 0, 0, 0), 0, '0);
        for (j = 1; j <= sweep_len + 8; j++) begin
            tx_phase = tx_phase + FWD_STEP;
            send_item(enc_item(tx_phase, 1'($urandom_range(1))), 0, '0);
            if (j == sweep_len || j % 16 == 0)
                send_item(mk_in(ACTION_TICK, 0, 0, 0), 0, '0);
        end
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;

        // Random phases, limits around the position; swapped in phase 3, extremes in 0
        for (ph = 0; ph < PHASES; ph++) begin
            wait_drain();
            lim_hi = 16'(door_pos + $urandom_range(1, 40));
            lim_lo = 16'(door_pos - $urandom_range(1, 40));
            if (ph == 0) begin
                write_cfg(CFG_UPPER_LIMIT, 16'h8000);
                write_cfg(CFG_LOWER_LIMIT, 16'h7FFF);
            end else if (ph == 3) begin
                write_cfg(CFG_UPPER_LIMIT, lim_lo);
                write_cfg(CFG_LOWER_LIMIT, lim_hi);
            end else begin
                write_cfg(CFG_UPPER_LIMIT, lim_hi);
                write_cfg(CFG_LOWER_LIMIT, lim_lo);
            end
            write_cfg(CFG_RESTORED, 16'($urandom_range(16'hFFFF)));
            wait_drain();
            tx_phase = enc_phase;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // fill the block while the receiver holds off
                if (ph == 2 && n == 20) begin
                    tx_idle_pct = 0;
                    hold_req++;
                end
                if (ph == 2 && n == 100) tx_idle_pct = IDLE_PCT;
                r = $urandom_range(99);
                if (r < 8) begin
                    noise = 4'($urandom_range(15));
                    it    = noise;
                    if (it.action == ACTION_ENCODER) tx_phase = {it.chan_a, it.chan_a ^ it.chan_b};
                end else if (r < 30) begin
                    it = mk_in(ACTION_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                               $urandom_range(3) == 0);
                end else begin
                    // legal step, biased toward the limit the door is heading for
                    case (cur_mode)
                        MODE_OPENING: fwd = ($urandom_range(99) < 80);
                        MODE_CLOSING: fwd = ($urandom_range(99) < 20);
                        default:      fwd = 1'($urandom_range(1));
                    endcase
                    tx_phase = fwd ? tx_phase + FWD_STEP : tx_phase + BACK_STEP;
                    it = enc_item(tx_phase, 1'($urandom_range(1)));
                end
                send_item(it, 0, '0);
            end
        end

        wait_drain();
        if (n_fail == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
